FILE: rtl/mva_pkg.sv
package mva_pkg;

    localparam int MAX_VERTICES = 128;
    localparam int MAX_KEYS     = 16;
    localparam int MAX_FRAMES   = 64;

    localparam int VIDX_W  = 7;
    localparam int KIDX_W  = 4;
    localparam int FIDX_W  = 6;
    localparam int COMP_W  = 16;
    localparam int CFG_W   = 32;
    localparam int FCNT_W  = 7;

    // integer part of the 16.16 animation time
    localparam int TIME_INT_W = CFG_W / 2;

    localparam int VADDR_W = $clog2(MAX_VERTICES);
    localparam int FRAME_W = $clog2(MAX_FRAMES);
    localparam int IADDR_W = $clog2(MAX_KEYS * MAX_FRAMES);
    localparam int VTX_W   = 3 * COMP_W;
    localparam int PROD_W  = 2 * COMP_W;

    // influence is 4.12 fixed point
    localparam int INFL_FRAC = 12;

    localparam int CMD_Q_DEPTH = 4;
    localparam int CMD_Q_AW    = $clog2(CMD_Q_DEPTH);
    localparam int RES_Q_DEPTH = 2;
    localparam int RES_Q_AW    = $clog2(RES_Q_DEPTH);

    // register select, paddr[2]
    typedef enum logic {
        REG_ANIM_TIME   = 1'b0,
        REG_FRAME_COUNT = 1'b1
    } t_reg;

    typedef enum logic [1:0] {
        FN_LOAD_VTX  = 2'd0,
        FN_LOAD_INFL = 2'd1,
        FN_APPLY     = 2'd2,
        FN_READ      = 2'd3
    } t_func;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_WR_VTX,
        OP_WR_INFL,
        OP_APPLY,
        OP_READ
    } t_op;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_WB,
        ST_OUT
    } t_bstate;

    typedef struct packed {
        t_op                 op;
        logic [VIDX_W-1:0]   vidx;
        logic                v_ok;
        logic [IADDR_W-1:0]  iaddr;
        logic [COMP_W-1:0]   x;
        logic [COMP_W-1:0]   y;
        logic [COMP_W-1:0]   z;
        logic [COMP_W-1:0]   w;
    } t_cmd;

    typedef struct packed {
        logic [VIDX_W-1:0] idx;
        logic [COMP_W-1:0] x;
        logic [COMP_W-1:0] y;
        logic [COMP_W-1:0] z;
    } t_res;

    // command queue head, front to back
    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_cmd_head;

    // result handoff, back to result queue
    typedef struct packed {
        logic push;
        t_res res;
    } t_res_push;

endpackage

FILE: rtl/mva_ram.sv
module mva_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/mva_front.sv
module mva_front import mva_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    output logic                o_full,
    input  logic [1:0]          i_func,
    input  logic [VIDX_W-1:0]   i_vertex_index,
    input  logic [KIDX_W-1:0]   i_key_index,
    input  logic [FIDX_W-1:0]   i_frame_index,
    input  logic [COMP_W-1:0]   i_comp_x,
    input  logic [COMP_W-1:0]   i_comp_y,
    input  logic [COMP_W-1:0]   i_comp_z,
    input  logic [COMP_W-1:0]   i_weight,
    input  logic [CFG_W-1:0]    i_anim_time,
    input  logic [FCNT_W-1:0]   i_frame_count,
    output t_cmd_head           o_head,
    input  logic                i_pop
);

    t_cmd                r_q [CMD_Q_DEPTH];
    logic [CMD_Q_AW-1:0] r_wp, r_rp;
    logic [CMD_Q_AW:0]   r_cnt;
    logic [CMD_Q_AW-1:0] n_wp, n_rp;
    logic [CMD_Q_AW:0]   n_cnt;

    logic [TIME_INT_W-1:0] w_fc;
    logic [TIME_INT_W-1:0] w_frame_a;
    logic [TIME_INT_W-1:0] w_frame_b;
    logic [FRAME_W-1:0]  w_frame;
    logic [FRAME_W-1:0]  w_fsel;
    logic                w_v_ok, w_k_ok, w_f_ok;
    logic                w_push;
    t_cmd                w_cmd;

    // current frame: upper half of time, clamped to frame_count-1 and table size
    always_comb begin
        w_fc      = (i_frame_count == '0) ? TIME_INT_W'(1) : TIME_INT_W'(i_frame_count);
        w_frame_a = i_anim_time[CFG_W-1:TIME_INT_W];
        if (w_frame_a >= w_fc) begin
            w_frame_a = w_fc - TIME_INT_W'(1);
        end
        w_frame_b = (w_frame_a >= TIME_INT_W'(MAX_FRAMES)) ? TIME_INT_W'(MAX_FRAMES - 1)
                                                            : w_frame_a;
        w_frame   = w_frame_b[FRAME_W-1:0];
    end

    assign w_v_ok = 32'(i_vertex_index) < MAX_VERTICES;
    assign w_k_ok = 32'(i_key_index) < MAX_KEYS;
    assign w_f_ok = 32'(i_frame_index) < MAX_FRAMES;

    always_comb begin
        w_cmd.vidx = i_vertex_index;
        w_cmd.v_ok = w_v_ok;
        w_cmd.x    = i_comp_x;
        w_cmd.y    = i_comp_y;
        w_cmd.z    = i_comp_z;
        w_cmd.w    = i_weight;
        w_cmd.op   = OP_NOP;
        w_fsel     = w_frame;
        unique case (t_func'(i_func))
            FN_LOAD_VTX: begin
                if (w_v_ok) w_cmd.op = OP_WR_VTX;
            end
            FN_LOAD_INFL: begin
                w_fsel = i_frame_index[FRAME_W-1:0];
                if (w_k_ok && w_f_ok) w_cmd.op = OP_WR_INFL;
            end
            FN_APPLY: begin
                if (w_v_ok && w_k_ok) w_cmd.op = OP_APPLY;
            end
            FN_READ: begin
                w_cmd.op = OP_READ;
            end
            default: begin
                w_cmd.op = OP_NOP;
            end
        endcase
        w_cmd.iaddr = IADDR_W'(i_key_index) * IADDR_W'(MAX_FRAMES) + IADDR_W'(w_fsel);
    end

    assign o_full = (r_cnt == (CMD_Q_AW + 1)'(CMD_Q_DEPTH));
    assign w_push = i_push && !o_full;

    always_comb begin
        n_wp  = w_push ? r_wp + CMD_Q_AW'(1) : r_wp;
        n_rp  = i_pop ? r_rp + CMD_Q_AW'(1) : r_rp;
        n_cnt = r_cnt + (CMD_Q_AW + 1)'(w_push) - (CMD_Q_AW + 1)'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_cmd;
        end
    end

    assign o_head.valid = (r_cnt != '0);
    assign o_head.cmd   = r_q[r_rp];

endmodule

FILE: rtl/mva_back.sv
module mva_back import mva_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cmd_head  i_head,
    output logic       o_pop,
    output t_res_push  o_res,
    input  logic       i_res_full
);

    t_bstate                   r_state, n_state;
    t_cmd                      r_cmd;
    logic signed [PROD_W-1:0]  r_px, r_py, r_pz;
    logic [VTX_W-1:0]          r_base;
    logic                      r_nz;

    logic                      w_vwe, w_vre, w_iwe, w_ire;
    logic [VADDR_W-1:0]        w_vwaddr;
    logic [VTX_W-1:0]          w_vwdata;
    logic [VTX_W-1:0]          w_vrdata;
    logic [COMP_W-1:0]         w_irdata;
    logic [COMP_W-1:0]         w_sx, w_sy, w_sz;

    mva_ram #(.WIDTH(VTX_W), .DEPTH(MAX_VERTICES)) u_vtx_ram (
        .i_clk   (i_clk),
        .i_we    (w_vwe),
        .i_waddr (w_vwaddr),
        .i_wdata (w_vwdata),
        .i_re    (w_vre),
        .i_raddr (i_head.cmd.vidx[VADDR_W-1:0]),
        .o_rdata (w_vrdata)
    );

    mva_ram #(.WIDTH(COMP_W), .DEPTH(MAX_KEYS * MAX_FRAMES)) u_infl_ram (
        .i_clk   (i_clk),
        .i_we    (w_iwe),
        .i_waddr (i_head.cmd.iaddr),
        .i_wdata (i_head.cmd.w),
        .i_re    (w_ire),
        .i_raddr (i_head.cmd.iaddr),
        .o_rdata (w_irdata)
    );

    // base + (delta*infl)>>>12, wrapped to 16 bits
    assign w_sx = r_base[3*COMP_W-1:2*COMP_W] + r_px[INFL_FRAC+COMP_W-1:INFL_FRAC];
    assign w_sy = r_base[2*COMP_W-1:COMP_W]   + r_py[INFL_FRAC+COMP_W-1:INFL_FRAC];
    assign w_sz = r_base[COMP_W-1:0]          + r_pz[INFL_FRAC+COMP_W-1:INFL_FRAC];

    always_comb begin
        n_state  = r_state;
        o_pop    = 1'b0;
        w_vwe    = 1'b0;
        w_vre    = 1'b0;
        w_iwe    = 1'b0;
        w_ire    = 1'b0;
        w_vwaddr = r_cmd.vidx[VADDR_W-1:0];
        w_vwdata = {w_sx, w_sy, w_sz};
        o_res.push  = 1'b0;
        o_res.res.idx = r_cmd.vidx;
        o_res.res.x = r_cmd.v_ok ? w_vrdata[3*COMP_W-1:2*COMP_W] : '0;
        o_res.res.y = r_cmd.v_ok ? w_vrdata[2*COMP_W-1:COMP_W]   : '0;
        o_res.res.z = r_cmd.v_ok ? w_vrdata[COMP_W-1:0]          : '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_head.valid) begin
                    o_pop = 1'b1;
                    case (i_head.cmd.op)
                        OP_WR_VTX: begin
                            w_vwe    = 1'b1;
                            w_vwaddr = i_head.cmd.vidx[VADDR_W-1:0];
                            w_vwdata = {i_head.cmd.x, i_head.cmd.y, i_head.cmd.z};
                        end
                        OP_WR_INFL: begin
                            w_iwe = 1'b1;
                        end
                        OP_APPLY: begin
                            w_vre   = 1'b1;
                            w_ire   = 1'b1;
                            n_state = ST_MUL;
                        end
                        OP_READ: begin
                            w_vre   = 1'b1;
                            n_state = ST_OUT;
                        end
                        default: begin
                            n_state = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_MUL: begin
                n_state = ST_WB;
            end
            ST_WB: begin
                w_vwe   = r_nz;
                n_state = ST_IDLE;
            end
            ST_OUT: begin
                if (!i_res_full) begin
                    o_res.push = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cmd <= i_head.cmd;
        end
        if (r_state == ST_MUL) begin
            r_px   <= $signed(r_cmd.x) * $signed(w_irdata);
            r_py   <= $signed(r_cmd.y) * $signed(w_irdata);
            r_pz   <= $signed(r_cmd.z) * $signed(w_irdata);
            r_base <= w_vrdata;
            r_nz   <= (w_irdata != '0);
        end
    end

endmodule

FILE: rtl/mva_resq.sv
module mva_resq import mva_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_res_push  i_in,
    output logic       o_full,
    output logic       o_empty,
    input  logic       i_pop,
    output t_res       o_res
);

    t_res                r_q [RES_Q_DEPTH];
    logic [RES_Q_AW-1:0] r_wp, r_rp;
    logic [RES_Q_AW:0]   r_cnt;
    logic                w_push, w_pop;

    assign o_full  = (r_cnt == (RES_Q_AW + 1)'(RES_Q_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign w_push  = i_in.push && !o_full;
    assign w_pop   = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) r_wp <= r_wp + RES_Q_AW'(1);
            if (w_pop)  r_rp <= r_rp + RES_Q_AW'(1);
            r_cnt <= r_cnt + (RES_Q_AW + 1)'(w_push) - (RES_Q_AW + 1)'(w_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= i_in.res;
        end
    end

    assign o_res = r_q[r_rp];

endmodule

FILE: rtl/morph_vertex_accumulator.sv
// channel   direction  handshake              words
// input     in         push / full            func, indices, xyz, weight
// result    out        pop / empty            index, xyz of a vertex read
// config    in/out     APB psel/penable/...   animation_time @0, frame_count @4
//
// The back sequencer does loads of a vertex or an influence in idle; a read waits
// in ST_OUT while results are full; a key delta: memory read, multiply, write back.
// A 4-word command queue lets input keep arriving while the back end works;
// a 2-word result queue keeps reads going while pop is held low.
// Synchronous active-low reset empties both queues; the stores are not cleared.
module morph_vertex_accumulator import mva_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                push,
    output logic                full,
    input  logic [1:0]          i_func,
    input  logic [VIDX_W-1:0]   i_vertex_index,
    input  logic [KIDX_W-1:0]   i_key_index,
    input  logic [FIDX_W-1:0]   i_frame_index,
    input  logic [COMP_W-1:0]   i_comp_x,
    input  logic [COMP_W-1:0]   i_comp_y,
    input  logic [COMP_W-1:0]   i_comp_z,
    input  logic [COMP_W-1:0]   i_weight,
    output logic                empty,
    input  logic                pop,
    output logic [VIDX_W-1:0]   o_out_index,
    output logic [COMP_W-1:0]   o_out_x,
    output logic [COMP_W-1:0]   o_out_y,
    output logic [COMP_W-1:0]   o_out_z,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [CFG_W-1:0]    pwdata,
    output logic [CFG_W-1:0]    prdata,
    output logic                pready
);

    logic [CFG_W-1:0]  r_anim_time;
    logic [FCNT_W-1:0] r_frame_count;
    logic              w_cfg_wr;

    t_cmd_head         w_head;
    logic              w_cmd_pop;
    t_res_push         w_res_push;
    logic              w_res_full;
    t_res              w_res;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_anim_time   <= '0;
            r_frame_count <= FCNT_W'(1);
        end else if (w_cfg_wr) begin
            if (paddr[2] == REG_ANIM_TIME) begin
                r_anim_time <= pwdata;
            end else begin
                r_frame_count <= pwdata[FCNT_W-1:0];
            end
        end
    end

    assign prdata = (paddr[2] == REG_FRAME_COUNT) ? CFG_W'(r_frame_count) : r_anim_time;

    mva_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (push),
        .o_full         (full),
        .i_func         (i_func),
        .i_vertex_index (i_vertex_index),
        .i_key_index    (i_key_index),
        .i_frame_index  (i_frame_index),
        .i_comp_x       (i_comp_x),
        .i_comp_y       (i_comp_y),
        .i_comp_z       (i_comp_z),
        .i_weight       (i_weight),
        .i_anim_time    (r_anim_time),
        .i_frame_count  (r_frame_count),
        .o_head         (w_head),
        .i_pop          (w_cmd_pop)
    );

    mva_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (w_head),
        .o_pop      (w_cmd_pop),
        .o_res      (w_res_push),
        .i_res_full (w_res_full)
    );

    mva_resq u_resq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (w_res_push),
        .o_full  (w_res_full),
        .o_empty (empty),
        .i_pop   (pop),
        .o_res   (w_res)
    );

    assign o_out_index = w_res.idx;
    assign o_out_x     = w_res.x;
    assign o_out_y     = w_res.y;
    assign o_out_z     = w_res.z;

endmodule

FILE: rtl/mva_checker.sv
module mva_checker import mva_pkg::*; (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                push,
    input logic                full,
    input logic                empty,
    input logic                pop,
    input logic [VIDX_W-1:0]   o_out_index,
    input logic [COMP_W-1:0]   o_out_x,
    input logic [COMP_W-1:0]   o_out_y,
    input logic [COMP_W-1:0]   o_out_z,
    input logic                psel,
    input logic                penable,
    input logic                pwrite,
    input logic [2:0]          paddr,
    input logic [CFG_W-1:0]    pwdata,
    input logic [CFG_W-1:0]    prdata,
    input logic                pready
);

    a_pready: assert property (@(posedge i_clk) pready)
        else $error("pready dropped");

    a_rst_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty && !full)
        else $error("queues not empty after reset");

    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> !empty && $stable(o_out_index) && $stable(o_out_x)
            && $stable(o_out_y) && $stable(o_out_z))
        else $error("waiting result word changed");

    // animation_time reads back what was written
    a_cfg_rb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (psel && penable && pwrite && pready && paddr[2] == REG_ANIM_TIME)
            ##1 (paddr[2] == REG_ANIM_TIME && !(psel && penable && pwrite))
        |-> prdata == $past(pwdata))
        else $error("animation_time readback mismatch");

endmodule

bind morph_vertex_accumulator mva_checker u_mva_checker (.*);
